// File: design/eul_pkg.sv
`default_nettype none
package eul_pkg;

    localparam int ANGLE_W = 12;
    localparam int ELEM_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int X2_W    = 15;
    localparam int LATENCY = 7;

    localparam logic [X2_W-1:0]    POLY_B       = 15'd19900;
    localparam logic [11:0]        POLY_C       = 12'd3516;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 12'd1024;
    localparam logic signed [ELEM_W-1:0] ONE_Q12 = 16'sd4096;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [2:0][ANGLE_W-1:0] angle3_t;
    typedef elem_t [2:0][2:0] mat3_t;

    typedef struct packed {
        elem_t [2:0] sin_v;
        elem_t [2:0] cos_v;
    } trig_t;

endpackage
`default_nettype wire

// File: design/eul_sincos.sv
`default_nettype none
module eul_sincos (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  eul_pkg::angle3_t angles,
    output logic            out_valid,
    output eul_pkg::trig_t  trig
);
    import eul_pkg::*;

    // six evaluations: sine of each angle, then cosine of each angle
    logic [ANGLE_W-1:0]      a_c   [6];
    logic [10:0]             d_c   [6];
    logic signed [10:0]      t_c   [6];
    logic signed [21:0]      sq_c  [6];

    logic [X2_W-1:0]         x2_reg   [6];
    logic                    half1_reg [6];
    logic                    v1_reg;

    logic [26:0]             p_c   [6];
    logic [X2_W-1:0]         y1_next [6];
    logic [X2_W-1:0]         y1_reg   [6];
    logic [X2_W-1:0]         x2b_reg  [6];
    logic                    half2_reg [6];
    logic                    v2_reg;

    logic [29:0]             q_c   [6];
    elem_t                   y_c   [6];
    elem_t                   res_next [6];
    elem_t                   res_reg  [6];
    logic                    v3_reg;

    // stage 1: fold onto the quarter-turn distance and square
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_c[k]     = angles[k];
            a_c[k + 3] = angles[k] + QUARTER_TURN;
        end
        for (int n = 0; n < 6; n++)
        begin
            d_c[n]  = a_c[n][10:0] - QUARTER_TURN[10:0];
            t_c[n]  = signed'(d_c[n]);
            sq_c[n] = t_c[n] * t_c[n];
        end
    end

    // stage 2: inner polynomial term
    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            p_c[n]     = x2_reg[n] * POLY_C;
            y1_next[n] = POLY_B - {2'b00, p_c[n][26:14]};
        end
    end

    // stage 3: outer term and half-circle sign
    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            q_c[n]      = x2b_reg[n] * y1_reg[n];
            y_c[n]      = ONE_Q12 - signed'({2'b00, q_c[n][29:16]});
            res_next[n] = half2_reg[n] ? -y_c[n] : y_c[n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 6; n++)
        begin
            x2_reg[n]    <= sq_c[n][20:6];
            half1_reg[n] <= a_c[n][11];
            y1_reg[n]    <= y1_next[n];
            x2b_reg[n]   <= x2_reg[n];
            half2_reg[n] <= half1_reg[n];
            res_reg[n]   <= res_next[n];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trig.sin_v[k] = res_reg[k];
            trig.cos_v[k] = res_reg[k + 3];
        end
    end

    assign out_valid = v3_reg;

endmodule
`default_nettype wire

// File: design/eul_rot_mul.sv
`default_nettype none
module eul_rot_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  eul_pkg::trig_t trig,
    output logic           out_valid,
    output eul_pkg::mat3_t mat
);
    import eul_pkg::*;

    function automatic elem_t asr_trunc(input logic signed [31:0] v);
        logic signed [31:0] sh;
        sh = v >>> FRAC_W;
        return sh[ELEM_W-1:0];
    endfunction

    // stage a: products for rx*ry
    logic signed [31:0] s0s1_reg, s0c1_reg, c0s1_reg, c0c1_reg;
    elem_t              s0a_reg, c0a_reg, s1a_reg, c1a_reg, s2a_reg, c2a_reg;
    logic               va_reg;

    // stage b: rx*ry
    mat3_t              tmp_next, tmp_reg;
    elem_t              s2b_reg, c2b_reg;
    logic               vb_reg;

    // stage c: products for (rx*ry)*rz
    logic signed [31:0] m_next [3][4];
    logic signed [31:0] m_reg  [3][4];
    elem_t              col2_reg [3];
    logic               vc_reg;

    // stage d: final sums
    mat3_t              res_next, res_reg;
    logic               vd_reg;

    always_comb
    begin
        tmp_next[0][0] = c1a_reg;
        tmp_next[0][1] = '0;
        tmp_next[0][2] = s1a_reg;
        tmp_next[1][0] = asr_trunc(s0s1_reg);
        tmp_next[1][1] = c0a_reg;
        tmp_next[1][2] = asr_trunc(-s0c1_reg);
        tmp_next[2][0] = asr_trunc(-c0s1_reg);
        tmp_next[2][1] = s0a_reg;
        tmp_next[2][2] = asr_trunc(c0c1_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_next[i][0] = tmp_reg[i][0] * c2b_reg;
            m_next[i][1] = tmp_reg[i][1] * s2b_reg;
            m_next[i][2] = -(tmp_reg[i][0] * s2b_reg);
            m_next[i][3] = tmp_reg[i][1] * c2b_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_next[i][0] = asr_trunc(m_reg[i][0] + m_reg[i][1]);
            res_next[i][1] = asr_trunc(m_reg[i][2] + m_reg[i][3]);
            res_next[i][2] = col2_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0s1_reg <= trig.sin_v[0] * trig.sin_v[1];
        s0c1_reg <= trig.sin_v[0] * trig.cos_v[1];
        c0s1_reg <= trig.cos_v[0] * trig.sin_v[1];
        c0c1_reg <= trig.cos_v[0] * trig.cos_v[1];
        s0a_reg  <= trig.sin_v[0];
        c0a_reg  <= trig.cos_v[0];
        s1a_reg  <= trig.sin_v[1];
        c1a_reg  <= trig.cos_v[1];
        s2a_reg  <= trig.sin_v[2];
        c2a_reg  <= trig.cos_v[2];
        tmp_reg  <= tmp_next;
        s2b_reg  <= s2a_reg;
        c2b_reg  <= c2a_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                m_reg[i][j] <= m_next[i][j];
            end
            col2_reg[i] <= tmp_reg[i][2];
        end
        res_reg <= res_next;
    end

    assign out_valid = vd_reg;
    assign mat       = res_reg;

endmodule
`default_nettype wire

// File: design/euler_rotation_matrix.sv
// channel   direction  transfer when        payload
// command   in         start && !busy       angle_x, angle_y, angle_z
// result    out        done (one cycle)     elem_00 .. elem_22
//
// one command accepted every cycle, busy is never raised
// result passes through 3 sine/cosine stages, then 4 matrix stages
// the stage count is set by the polynomial multipliers and the two matrix products
// reset clears only the valid bits; results are never held off by the receiver
`default_nettype none
module euler_rotation_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   angle_x,
    input  logic signed [15:0]   angle_y,
    input  logic signed [15:0]   angle_z,
    output logic                 done,
    output eul_pkg::elem_t       elem_00,
    output eul_pkg::elem_t       elem_01,
    output eul_pkg::elem_t       elem_02,
    output eul_pkg::elem_t       elem_10,
    output eul_pkg::elem_t       elem_11,
    output eul_pkg::elem_t       elem_12,
    output eul_pkg::elem_t       elem_20,
    output eul_pkg::elem_t       elem_21,
    output eul_pkg::elem_t       elem_22
);
    import eul_pkg::*;

    angle3_t angles;
    trig_t   trig;
    logic    trig_valid;
    mat3_t   mat;
    logic    mat_valid;

    assign busy = 1'b0;

    assign angles[0] = angle_x[ANGLE_W-1:0];
    assign angles[1] = angle_y[ANGLE_W-1:0];
    assign angles[2] = angle_z[ANGLE_W-1:0];

    eul_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .angles    (angles),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    eul_rot_mul u_rot_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .trig      (trig),
        .out_valid (mat_valid),
        .mat       (mat)
    );

    assign done    = mat_valid;
    assign elem_00 = mat[0][0];
    assign elem_01 = mat[0][1];
    assign elem_02 = mat[0][2];
    assign elem_10 = mat[1][0];
    assign elem_11 = mat[1][1];
    assign elem_12 = mat[1][2];
    assign elem_20 = mat[2][0];
    assign elem_21 = mat[2][1];
    assign elem_22 = mat[2][2];

    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a command");

    a_cmd_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start && !busy, LATENCY) |-> !done)
        else $error("result at wrong latency");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !busy)
        else $error("busy raised");

endmodule
`default_nettype wire
